FILE: sv/cnn_pkg.sv
// shared types and constants of the cosine nearest-neighbour core
`default_nettype none
package cnn_pkg;

  localparam int ELEM_W = 16;
  localparam int IDX_W  = 9;
  localparam int VLEN_W = 10;
  localparam int CMD_W  = 2;
  localparam int SLOT_W = 20;
  localparam int SEEN_W = 21;
  localparam int DOT_W  = 42;
  localparam int MAG_W  = 41;

  localparam logic [VLEN_W-1:0] VLEN_RESET = 10'd100;

  localparam logic [CMD_W-1:0] CMD_LOAD   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_CAND   = 2'd1;
  localparam logic [CMD_W-1:0] CMD_FINISH = 2'd2;

  localparam int QDEPTH = 4;
  localparam int QPTR_W = 2;
  localparam int QCNT_W = 3;

  localparam int MUL_XW    = 84;
  localparam int MUL_DW    = 8;
  localparam int MUL_STEPS = 6;
  localparam int MUL_YW    = MUL_DW * MUL_STEPS;
  localparam int MUL_PW    = MUL_XW + MUL_YW;
  localparam int MUL_CNT_W = 3;

  typedef struct packed {
    logic                     finish;
    logic                     last;
    logic signed [ELEM_W-1:0] q;
    logic signed [ELEM_W-1:0] v;
  } cnn_item_t;

endpackage
`default_nettype wire

FILE: sv/cnn_ram.sv
// generic single-port ram with registered read
`default_nettype none
module cnn_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 512,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic             re,
  input  wire logic [AW-1:0]    addr,
  input  wire logic [WIDTH-1:0] wdata,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[addr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[addr];
    end
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

FILE: sv/cnn_front.sv
// front end: takes commands, owns the query store, classifies candidate elements
`default_nettype none
module cnn_front #(
  parameter int MAX_DIM = 512
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              start,
  output logic                                   busy,
  input  wire logic        [cnn_pkg::CMD_W-1:0]  in_cmd,
  input  wire logic        [cnn_pkg::IDX_W-1:0]  in_idx,
  input  wire logic signed [cnn_pkg::ELEM_W-1:0] in_value,
  input  wire logic        [cnn_pkg::VLEN_W-1:0] vlen,
  input  wire logic        [cnn_pkg::QCNT_W-1:0] q_count,
  output logic                                   push,
  output cnn_pkg::cnn_item_t                     push_item
);

  localparam int AW = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;

  logic                              accept;
  logic                              in_range;
  logic                              is_last;
  logic                              ram_we;
  logic                              ram_re;
  logic [AW-1:0]                     ram_addr;
  logic [cnn_pkg::ELEM_W-1:0]        ram_rdata;
  logic [cnn_pkg::QCNT_W:0]          occupancy;

  logic                              s1_valid_r, s1_valid_nxt;
  logic                              s1_finish_r, s1_finish_nxt;
  logic                              s1_last_r, s1_last_nxt;
  logic                              s1_hit_r, s1_hit_nxt;
  logic signed [cnn_pkg::ELEM_W-1:0] s1_v_r, s1_v_nxt;

  assign occupancy = (cnn_pkg::QCNT_W+1)'(q_count) + (cnn_pkg::QCNT_W+1)'(s1_valid_r);
  assign busy      = occupancy >= (cnn_pkg::QCNT_W+1)'(cnn_pkg::QDEPTH);
  assign accept    = start && !busy;
  assign in_range  = 32'(in_idx) < MAX_DIM;
  assign is_last   = ({1'b0, in_idx} + 10'd1) == vlen;
  assign ram_addr  = AW'(in_idx);
  assign ram_we    = accept && (in_cmd == cnn_pkg::CMD_LOAD) && in_range;
  assign ram_re    = accept && (in_cmd == cnn_pkg::CMD_CAND) && in_range;

  cnn_ram #(
    .WIDTH (cnn_pkg::ELEM_W),
    .DEPTH (MAX_DIM)
  ) u_query (
    .clk   (clk),
    .we    (ram_we),
    .re    (ram_re),
    .addr  (ram_addr),
    .wdata (in_value),
    .rdata (ram_rdata)
  );

  always_comb begin
    s1_valid_nxt  = 1'b0;
    s1_finish_nxt = 1'b0;
    s1_last_nxt   = s1_last_r;
    s1_hit_nxt    = s1_hit_r;
    s1_v_nxt      = s1_v_r;
    if (accept) begin
      unique case (in_cmd)
        cnn_pkg::CMD_CAND: begin
          s1_valid_nxt = 1'b1;
          s1_last_nxt  = is_last;
          s1_hit_nxt   = in_range;
          s1_v_nxt     = in_value;
        end
        cnn_pkg::CMD_FINISH: begin
          s1_valid_nxt  = 1'b1;
          s1_finish_nxt = 1'b1;
          s1_last_nxt   = 1'b0;
          s1_hit_nxt    = 1'b0;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      s1_finish_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      s1_finish_r <= s1_finish_nxt;
    end
    s1_last_r <= s1_last_nxt;
    s1_hit_r  <= s1_hit_nxt;
    s1_v_r    <= s1_v_nxt;
  end

  assign push             = s1_valid_r;
  assign push_item.finish = s1_finish_r;
  assign push_item.last   = s1_last_r;
  assign push_item.q      = s1_hit_r ? $signed(ram_rdata) : '0;
  assign push_item.v      = s1_v_r;

endmodule
`default_nettype wire

FILE: sv/cnn_queue.sv
// short fifo between front and back end
`default_nettype none
module cnn_queue (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       push,
  input  wire cnn_pkg::cnn_item_t         push_item,
  input  wire logic                       pop,
  output cnn_pkg::cnn_item_t              pop_item,
  output logic                            empty,
  output logic [cnn_pkg::QCNT_W-1:0]      count
);

  cnn_pkg::cnn_item_t               mem_r [cnn_pkg::QDEPTH];
  logic [cnn_pkg::QPTR_W-1:0]       wr_ptr_r, wr_ptr_nxt;
  logic [cnn_pkg::QPTR_W-1:0]       rd_ptr_r, rd_ptr_nxt;
  logic [cnn_pkg::QCNT_W-1:0]       count_r, count_nxt;

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r + cnn_pkg::QCNT_W'(push) - cnn_pkg::QCNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

  assign pop_item = mem_r[rd_ptr_r];
  assign empty    = count_r == '0;
  assign count    = count_r;

endmodule
`default_nettype wire

FILE: sv/cnn_mul.sv
// iterative multiplier, one 8-bit digit of the multiplier per cycle, msb first
`default_nettype none
module cnn_mul (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         start,
  input  wire logic [cnn_pkg::MUL_XW-1:0]   x,
  input  wire logic [cnn_pkg::MUL_YW-1:0]   y,
  output logic                              done,
  output logic [cnn_pkg::MUL_PW-1:0]        p
);

  logic [cnn_pkg::MUL_PW-1:0]          acc_r, acc_nxt;
  logic [cnn_pkg::MUL_XW-1:0]          x_r, x_nxt;
  logic [cnn_pkg::MUL_YW-1:0]          y_r, y_nxt;
  logic [cnn_pkg::MUL_CNT_W-1:0]       cnt_r, cnt_nxt;
  logic                                done_r, done_nxt;
  logic [cnn_pkg::MUL_XW+cnn_pkg::MUL_DW-1:0] partial;

  assign partial = x_r * y_r[cnn_pkg::MUL_YW-1 -: cnn_pkg::MUL_DW];

  always_comb begin
    acc_nxt  = acc_r;
    x_nxt    = x_r;
    y_nxt    = y_r;
    cnt_nxt  = cnt_r;
    done_nxt = 1'b0;
    if (start) begin
      acc_nxt = '0;
      x_nxt   = x;
      y_nxt   = y;
      cnt_nxt = cnn_pkg::MUL_CNT_W'(cnn_pkg::MUL_STEPS);
    end else if (cnt_r != '0) begin
      acc_nxt  = {acc_r[cnn_pkg::MUL_PW-cnn_pkg::MUL_DW-1:0], cnn_pkg::MUL_DW'(0)}
               + cnn_pkg::MUL_PW'(partial);
      y_nxt    = {y_r[cnn_pkg::MUL_YW-cnn_pkg::MUL_DW-1:0], cnn_pkg::MUL_DW'(0)};
      cnt_nxt  = cnt_r - 1'b1;
      done_nxt = cnt_r == cnn_pkg::MUL_CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      done_r <= done_nxt;
    end
    acc_r <= acc_nxt;
    x_r   <= x_nxt;
    y_r   <= y_nxt;
  end

  assign done = done_r;
  assign p    = acc_r;

endmodule
`default_nettype wire

FILE: sv/cnn_back.sv
// back end: accumulates dot product and magnitude, compares scores, reports on finish
`default_nettype none
module cnn_back #(
  parameter int MAX_CANDIDATES = 1048576
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         q_empty,
  input  wire cnn_pkg::cnn_item_t           pop_item,
  output logic                              pop,
  output logic                              out_valid,
  output logic [cnn_pkg::SLOT_W-1:0]        out_best_index,
  output logic                              out_found,
  output logic [cnn_pkg::SEEN_W-1:0]        out_candidates_seen
);

  localparam int CW = $clog2(MAX_CANDIDATES + 1);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_DECIDE = 3'd1;
  localparam logic [2:0] ST_SQ_A   = 3'd2;
  localparam logic [2:0] ST_MUL_L  = 3'd3;
  localparam logic [2:0] ST_SQ_B   = 3'd4;
  localparam logic [2:0] ST_MUL_R  = 3'd5;

  logic [2:0]                         state_r, state_nxt;
  logic signed [cnn_pkg::DOT_W-1:0]   dot_r, dot_nxt;
  logic [cnn_pkg::MAG_W-1:0]          mag_r, mag_nxt;
  logic signed [cnn_pkg::DOT_W-1:0]   best_dot_r, best_dot_nxt;
  logic [cnn_pkg::MAG_W-1:0]          best_mag_r, best_mag_nxt;
  logic [cnn_pkg::SLOT_W-1:0]         best_slot_r, best_slot_nxt;
  logic [CW-1:0]                      count_r, count_nxt;
  logic                               have_best_r, have_best_nxt;
  logic [cnn_pkg::MUL_PW-1:0]         lhs_r, lhs_nxt;
  logic                               out_valid_r, out_valid_nxt;
  logic [cnn_pkg::SLOT_W-1:0]         out_index_r, out_index_nxt;
  logic                               out_found_r, out_found_nxt;
  logic [cnn_pkg::SEEN_W-1:0]         out_seen_r, out_seen_nxt;

  logic signed [2*cnn_pkg::ELEM_W-1:0] qv_prod;
  logic signed [2*cnn_pkg::ELEM_W-1:0] vv_prod;
  logic signed [cnn_pkg::DOT_W-1:0]    dot_acc;
  logic [cnn_pkg::MAG_W-1:0]           mag_acc;
  logic [cnn_pkg::DOT_W-1:0]           ad;
  logic [cnn_pkg::DOT_W-1:0]           ab;
  logic [1:0]                          sd_rank;
  logic [1:0]                          sb_rank;
  logic                                resolve;
  logic                                cand_wins;
  logic                                mul_start;
  logic [cnn_pkg::MUL_XW-1:0]          mul_x;
  logic [cnn_pkg::MUL_YW-1:0]          mul_y;
  logic                                mul_done;
  logic [cnn_pkg::MUL_PW-1:0]          mul_p;

  cnn_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start),
    .x     (mul_x),
    .y     (mul_y),
    .done  (mul_done),
    .p     (mul_p)
  );

  assign qv_prod = pop_item.q * pop_item.v;
  assign vv_prod = pop_item.v * pop_item.v;
  assign dot_acc = dot_r + cnn_pkg::DOT_W'(qv_prod);
  assign mag_acc = mag_r + cnn_pkg::MAG_W'(vv_prod);
  assign ad      = dot_r[cnn_pkg::DOT_W-1] ? -dot_r : dot_r;
  assign ab      = best_dot_r[cnn_pkg::DOT_W-1] ? -best_dot_r : best_dot_r;

  // rank of the sign: negative, zero, positive
  assign sd_rank = dot_r[cnn_pkg::DOT_W-1] ? 2'd0 : ((dot_r == '0) ? 2'd1 : 2'd2);
  assign sb_rank = best_dot_r[cnn_pkg::DOT_W-1] ? 2'd0 : ((best_dot_r == '0) ? 2'd1 : 2'd2);

  always_comb begin
    state_nxt     = state_r;
    dot_nxt       = dot_r;
    mag_nxt       = mag_r;
    best_dot_nxt  = best_dot_r;
    best_mag_nxt  = best_mag_r;
    best_slot_nxt = best_slot_r;
    count_nxt     = count_r;
    have_best_nxt = have_best_r;
    lhs_nxt       = lhs_r;
    out_valid_nxt = 1'b0;
    out_index_nxt = out_index_r;
    out_found_nxt = out_found_r;
    out_seen_nxt  = out_seen_r;
    pop           = 1'b0;
    resolve       = 1'b0;
    cand_wins     = 1'b0;
    mul_start     = 1'b0;
    mul_x         = '0;
    mul_y         = '0;

    unique case (state_r)
      ST_IDLE: begin
        if (!q_empty) begin
          pop = 1'b1;
          if (pop_item.finish) begin
            out_valid_nxt = 1'b1;
            out_index_nxt = have_best_r ? best_slot_r : '0;
            out_found_nxt = have_best_r;
            out_seen_nxt  = cnn_pkg::SEEN_W'(count_r);
            dot_nxt       = '0;
            mag_nxt       = '0;
            best_dot_nxt  = '0;
            best_mag_nxt  = '0;
            best_slot_nxt = '0;
            count_nxt     = '0;
            have_best_nxt = 1'b0;
          end else begin
            dot_nxt = dot_acc;
            mag_nxt = mag_acc;
            if (pop_item.last) begin
              state_nxt = ST_DECIDE;
            end
          end
        end
      end
      ST_DECIDE: begin
        if (count_r >= CW'(MAX_CANDIDATES)) begin
          dot_nxt   = '0;
          mag_nxt   = '0;
          state_nxt = ST_IDLE;
        end else if (mag_r == '0) begin
          resolve = 1'b1;
        end else if (!have_best_r) begin
          resolve   = 1'b1;
          cand_wins = 1'b1;
        end else if (sd_rank != sb_rank) begin
          resolve   = 1'b1;
          cand_wins = sd_rank > sb_rank;
        end else if (sd_rank == 2'd1) begin
          resolve = 1'b1;
        end else begin
          mul_start = 1'b1;
          mul_x     = cnn_pkg::MUL_XW'(ad);
          mul_y     = cnn_pkg::MUL_YW'(ad);
          state_nxt = ST_SQ_A;
        end
      end
      ST_SQ_A: begin
        if (mul_done) begin
          mul_start = 1'b1;
          mul_x     = mul_p[cnn_pkg::MUL_XW-1:0];
          mul_y     = cnn_pkg::MUL_YW'(best_mag_r);
          state_nxt = ST_MUL_L;
        end
      end
      ST_MUL_L: begin
        if (mul_done) begin
          lhs_nxt   = mul_p;
          mul_start = 1'b1;
          mul_x     = cnn_pkg::MUL_XW'(ab);
          mul_y     = cnn_pkg::MUL_YW'(ab);
          state_nxt = ST_SQ_B;
        end
      end
      ST_SQ_B: begin
        if (mul_done) begin
          mul_start = 1'b1;
          mul_x     = mul_p[cnn_pkg::MUL_XW-1:0];
          mul_y     = cnn_pkg::MUL_YW'(mag_r);
          state_nxt = ST_MUL_R;
        end
      end
      ST_MUL_R: begin
        if (mul_done) begin
          resolve   = 1'b1;
          cand_wins = dot_r[cnn_pkg::DOT_W-1] ? (lhs_r < mul_p) : (lhs_r > mul_p);
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    if (resolve) begin
      if (cand_wins) begin
        best_dot_nxt  = dot_r;
        best_mag_nxt  = mag_r;
        best_slot_nxt = cnn_pkg::SLOT_W'(count_r);
        have_best_nxt = 1'b1;
      end
      count_nxt = count_r + 1'b1;
      dot_nxt   = '0;
      mag_nxt   = '0;
      state_nxt = ST_IDLE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      dot_r       <= '0;
      mag_r       <= '0;
      best_dot_r  <= '0;
      best_mag_r  <= '0;
      best_slot_r <= '0;
      count_r     <= '0;
      have_best_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      dot_r       <= dot_nxt;
      mag_r       <= mag_nxt;
      best_dot_r  <= best_dot_nxt;
      best_mag_r  <= best_mag_nxt;
      best_slot_r <= best_slot_nxt;
      count_r     <= count_nxt;
      have_best_r <= have_best_nxt;
      out_valid_r <= out_valid_nxt;
    end
    lhs_r       <= lhs_nxt;
    out_index_r <= out_index_nxt;
    out_found_r <= out_found_nxt;
    out_seen_r  <= out_seen_nxt;
  end

  assign out_valid           = out_valid_r;
  assign out_best_index      = out_index_r;
  assign out_found           = out_found_r;
  assign out_candidates_seen = out_seen_r;

endmodule
`default_nettype wire

FILE: sv/cosine_nearest_neighbour_core.sv
// top level of the cosine-similarity nearest-neighbour search core
//
// Query loads and candidate elements are taken one per cycle while the four-entry
// queue between the front end and the back end has room. The back end accumulates
// each element as it pops it; a candidate's last element adds a decision state and,
// when its score and the best score share a nonzero sign, four passes of the shared
// 84x48 iterative multiplier, which works through six 8-bit digits in each pass;
// meanwhile the queue fills and busy rises. A finish gives its result on out_valid for
// exactly one cycle once it has passed the front-end stage register and the queue
// and has been popped by the back end; the receiver cannot stall it. The query store
// is not cleared after reset and must be loaded before candidates are sent.
`default_nettype none
module cosine_nearest_neighbour_core #(
  parameter int MAX_DIM        = 512,
  parameter int MAX_CANDIDATES = 1048576
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              start,
  output logic                                   busy,
  input  wire logic        [cnn_pkg::CMD_W-1:0]  in_cmd,
  input  wire logic        [cnn_pkg::IDX_W-1:0]  in_element_index,
  input  wire logic signed [cnn_pkg::ELEM_W-1:0] in_element_value,
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic        [cnn_pkg::VLEN_W-1:0] cfg_vector_length,
  output logic                                   out_valid,
  output logic             [cnn_pkg::SLOT_W-1:0] out_best_index,
  output logic                                   out_found,
  output logic             [cnn_pkg::SEEN_W-1:0] out_candidates_seen
);

  logic [cnn_pkg::VLEN_W-1:0] vlen_r, vlen_nxt;
  logic                       push;
  cnn_pkg::cnn_item_t         push_item;
  logic                       pop;
  cnn_pkg::cnn_item_t         pop_item;
  logic                       q_empty;
  logic [cnn_pkg::QCNT_W-1:0] q_count;

  assign cfg_ready = 1'b1;
  assign vlen_nxt  = (cfg_valid && cfg_ready) ? cfg_vector_length : vlen_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vlen_r <= cnn_pkg::VLEN_RESET;
    end else begin
      vlen_r <= vlen_nxt;
    end
  end

  cnn_front #(
    .MAX_DIM (MAX_DIM)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_cmd    (in_cmd),
    .in_idx    (in_element_index),
    .in_value  (in_element_value),
    .vlen      (vlen_r),
    .q_count   (q_count),
    .push      (push),
    .push_item (push_item)
  );

  cnn_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .pop_item  (pop_item),
    .empty     (q_empty),
    .count     (q_count)
  );

  cnn_back #(
    .MAX_CANDIDATES (MAX_CANDIDATES)
  ) u_back (
    .clk                 (clk),
    .rst_n               (rst_n),
    .q_empty             (q_empty),
    .pop_item            (pop_item),
    .pop                 (pop),
    .out_valid           (out_valid),
    .out_best_index      (out_best_index),
    .out_found           (out_found),
    .out_candidates_seen (out_candidates_seen)
  );

endmodule
`default_nettype wire
